// File: sv/pdl_pkg.sv
package pdl_pkg;

  localparam logic signed [47:0] QMAX = 48'sh7FFF_FFFF_FFFF;

  localparam logic [30:0] RST_RADIUS = 31'd65536;
  localparam logic [30:0] RST_MASS   = 31'd65536;
  localparam logic [30:0] RST_REST   = 31'd65536000;
  localparam logic [30:0] RST_CFM    = 31'd6553600;
  localparam logic signed [31:0] RST_POLY6 = 32'sd102681;
  localparam logic signed [31:0] RST_SPIKY = -32'sd938731;

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_MASS   = 3'd1;
  localparam logic [2:0] REG_REST   = 3'd2;
  localparam logic [2:0] REG_CFM    = 3'd3;
  localparam logic [2:0] REG_POLY6  = 3'd4;
  localparam logic [2:0] REG_SPIKY  = 3'd5;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] d;
  } div_req_t;

  function automatic logic signed [47:0] add48(input logic signed [47:0] a,
                                               input logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s > 49'sh0_7FFF_FFFF_FFFF) return QMAX;
    else if (s < -49'sh0_7FFF_FFFF_FFFF) return -QMAX;
    else return s[47:0];
  endfunction

  function automatic logic [63:0] uadd64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sh0000_7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (v < -48'sh0000_8000_0000) return 32'sh8000_0000;
    else return v[31:0];
  endfunction

endpackage

// File: sv/pdl_mul.sv
module pdl_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  pdl_pkg::mul_req_t  req,
  output logic               done,
  output logic signed [47:0] res,
  output logic [63:0]        lo
);

  logic               busy_r;
  logic [2:0]         cnt_r;
  logic [63:0]        ma_r;
  logic [63:0]        mb_r;
  logic               neg_r;
  logic [63:0]        pp_r;
  logic [1:0]         sh_r;
  logic [127:0]       acc_r;
  logic               done_r;
  logic signed [47:0] res_r;
  logic [63:0]        lo_r;

  logic [31:0]  ha;
  logic [31:0]  hb;
  logic [127:0] pp_sh;
  logic [63:0]  m;
  logic [47:0]  m48;

  function automatic logic [63:0] mag(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  always_comb begin
    ha = cnt_r[0] ? ma_r[63:32] : ma_r[31:0];
    hb = cnt_r[1] ? mb_r[63:32] : mb_r[31:0];
    unique case (sh_r)
      2'd0:    pp_sh = {64'd0, pp_r};
      2'd1:    pp_sh = {32'd0, pp_r, 32'd0};
      default: pp_sh = {pp_r, 64'd0};
    endcase
    if (|acc_r[127:80]) m = {16'd0, pdl_pkg::QMAX};
    else if (acc_r[79:16] > {16'd0, pdl_pkg::QMAX}) m = {16'd0, pdl_pkg::QMAX};
    else m = acc_r[79:16];
    m48 = m[47:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
        ma_r   <= mag(req.a);
        mb_r   <= mag(req.b);
        neg_r  <= req.a[63] ^ req.b[63];
        acc_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r < 3'd4) begin
          pp_r <= ha * hb;
          sh_r <= {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
        end
        if (cnt_r != 3'd0 && cnt_r != 3'd5) begin
          acc_r <= acc_r + pp_sh;
        end
        if (cnt_r == 3'd5) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          res_r  <= neg_r ? -$signed(m48) : $signed(m48);
          lo_r   <= acc_r[63:0];
        end
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign lo   = lo_r;

endmodule

// File: sv/pdl_div.sv
module pdl_div (
  input  logic              clk,
  input  logic              rst_n,
  input  pdl_pkg::div_req_t req,
  output logic              done,
  output logic [63:0]       q
);

  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [63:0] r_r;
  logic [63:0] lo_r;
  logic [63:0] q_r;
  logic [63:0] d_r;
  logic        done_r;

  logic [63:0] r2;
  logic        take;

  always_comb begin
    r2   = {r_r[62:0], lo_r[63]};
    take = r_r[63] || (r2 >= d_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.d == 64'd0 || req.hi >= req.d) begin
          q_r    <= '1;
          done_r <= 1'b1;
          busy_r <= 1'b0;
        end else begin
          busy_r <= 1'b1;
          r_r    <= req.hi;
          lo_r   <= req.lo;
          d_r    <= req.d;
          q_r    <= '0;
          cnt_r  <= 6'd0;
        end
      end else if (busy_r) begin
        r_r   <= take ? r2 - d_r : r2;
        lo_r  <= {lo_r[62:0], 1'b0};
        q_r   <= {q_r[62:0], take};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

// File: sv/pdl_sqrt.sv
module pdl_sqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] v,
  output logic        done,
  output logic [31:0] root
);

  logic        busy_r;
  logic [4:0]  idx_r;
  logic [63:0] v_r;
  logic [63:0] res_r;
  logic        done_r;

  logic [63:0] bitv;
  logic [63:0] rb;
  logic        ge;

  always_comb begin
    bitv = 64'd1 << {~idx_r, 1'b0};
    rb   = res_r + bitv;
    ge   = v_r >= rb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= 5'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        idx_r  <= 5'd0;
        v_r    <= v;
        res_r  <= '0;
      end else if (busy_r) begin
        if (ge) begin
          v_r   <= v_r - rb;
          res_r <= (res_r >> 1) + bitv;
        end else begin
          res_r <= res_r >> 1;
        end
        idx_r <= idx_r + 5'd1;
        if (idx_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = res_r[31:0];

endmodule

// File: sv/pbf_density_lambda.sv
// Density and constraint multiplier of one fluid particle in Q16.16. The block takes one
// neighbour record per item and returns an item of density, lambda and neighbour count on the
// record marked last. Every product goes through one shared multiplier of four 32x32 partial
// products, square roots through a one-bit-a-cycle unit and quotients through a one-bit-a-cycle
// divider that skips the iteration when the quotient saturates. A last record adds the final
// lambda chain, and the next item is taken in the idle cycle that follows. The input is not
// ready while an item is being worked on; a finished result waits in an output register.
module pbf_density_lambda (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // center_x, center_y, center_z, neighbor_x, neighbor_y, neighbor_z
  input  logic [191:0] in_tdata,
  // is_self
  input  logic         in_tuser,
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  // density_out, lambda_out, neighbor_count
  output logic [79:0]  out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MP   = 5'd1;
  localparam logic [4:0] S_H2   = 5'd2;
  localparam logic [4:0] S_H4   = 5'd3;
  localparam logic [4:0] S_H6   = 5'd4;
  localparam logic [4:0] S_DS   = 5'd5;
  localparam logic [4:0] S_D2   = 5'd6;
  localparam logic [4:0] S_HS   = 5'd7;
  localparam logic [4:0] S_CHK  = 5'd8;
  localparam logic [4:0] S_W2   = 5'd9;
  localparam logic [4:0] S_W3   = 5'd10;
  localparam logic [4:0] S_WD   = 5'd11;
  localparam logic [4:0] S_SQ   = 5'd12;
  localparam logic [4:0] S_DD   = 5'd13;
  localparam logic [4:0] S_SP   = 5'd14;
  localparam logic [4:0] S_UD   = 5'd15;
  localparam logic [4:0] S_G    = 5'd16;
  localparam logic [4:0] S_GG   = 5'd17;
  localparam logic [4:0] S_FIN  = 5'd18;
  localparam logic [4:0] S_T    = 5'd19;
  localparam logic [4:0] S_RR   = 5'd20;
  localparam logic [4:0] S_GT   = 5'd21;
  localparam logic [4:0] S_Q    = 5'd22;
  localparam logic [4:0] S_L    = 5'd23;
  localparam logic [4:0] S_OUT  = 5'd24;

  logic [30:0]        radius_r;
  logic [30:0]        mass_r;
  logic [30:0]        rest_r;
  logic [30:0]        cfm_r;
  logic signed [31:0] poly6_r;
  logic signed [31:0] spiky_r;

  logic [4:0]         state_r;
  logic               wait_r;
  logic [1:0]         idx_r;
  logic signed [32:0] vec_r [3];
  logic               self_r;
  logic               last_r;
  logic signed [47:0] mp_r;
  logic signed [63:0] t1_r;
  logic signed [47:0] t2_r;
  logic signed [47:0] s_r;
  logic signed [47:0] g_r;
  logic [63:0]        d2_r;
  logic [63:0]        hsq_r;
  logic [31:0]        dist_r;
  logic signed [47:0] dens_r;
  logic signed [47:0] sum_r [3];
  logic [63:0]        gsq_r;
  logic [15:0]        cnt_r;
  logic [63:0]        tot_r;
  logic [63:0]        rr_r;
  logic [63:0]        denom_r;
  logic [63:0]        cmag_r;
  logic               cneg_r;
  logic [63:0]        lmag_r;

  logic               out_valid_r;
  logic signed [31:0] od_dens_r;
  logic signed [31:0] od_lam_r;
  logic [15:0]        od_cnt_r;

  pdl_pkg::mul_req_t  mreq;
  pdl_pkg::div_req_t  dreq;
  logic               sq_start;
  logic               mul_done;
  logic signed [47:0] mul_res;
  logic [63:0]        mul_lo;
  logic               div_done;
  logic [63:0]        div_q;
  logic               sq_done;
  logic [31:0]        sq_root;

  logic               unit_done;
  logic               cfg_wr;
  logic               out_load;
  logic [32:0]        vmag;
  logic [30:0]        restp;
  logic [47:0]        dmag;
  logic signed [31:0] lam;
  logic [63:0]        udiff;
  logic [31:0]        lneg_mag;

  function automatic logic signed [63:0] ext48(input logic signed [47:0] x);
    return {{16{x[47]}}, x};
  endfunction

  pdl_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .done (mul_done),
    .res  (mul_res),
    .lo   (mul_lo)
  );

  pdl_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .done (div_done),
    .q    (div_q)
  );

  pdl_sqrt u_sqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .v    (d2_r),
    .done (sq_done),
    .root (sq_root)
  );

  always_comb begin
    vmag      = vec_r[idx_r][32] ? 33'(-vec_r[idx_r]) : 33'(vec_r[idx_r]);
    restp     = (rest_r == 31'd0) ? 31'd1 : rest_r;
    dmag      = dens_r[47] ? 48'(-dens_r) : 48'(dens_r);
    unit_done = mul_done | div_done | sq_done;
    cfg_wr    = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
    out_load  = (state_r == S_OUT) && (!out_valid_r || out_tready);
    udiff     = hsq_r - d2_r;
    lneg_mag  = 32'(-lmag_r[31:0]);

    if (cneg_r) begin
      lam = (lmag_r >= 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(lmag_r[31:0]);
    end else begin
      lam = (lmag_r >= 64'h8000_0000) ? 32'sh8000_0000 : $signed(lneg_mag);
    end

    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;
    unique case (state_r)
      S_MP: begin
        mreq.start = !wait_r;
        mreq.a     = {33'd0, mass_r};
        mreq.b     = {{32{poly6_r[31]}}, poly6_r};
      end
      S_H2, S_HS: begin
        mreq.start = !wait_r;
        mreq.a     = {33'd0, radius_r};
        mreq.b     = {33'd0, radius_r};
      end
      S_H4, S_W2, S_DD: begin
        mreq.start = !wait_r;
        mreq.a     = t1_r;
        mreq.b     = t1_r;
      end
      S_H6, S_W3: begin
        mreq.start = !wait_r;
        mreq.a     = ext48(t2_r);
        mreq.b     = t1_r;
      end
      S_DS, S_WD: begin
        mreq.start = !wait_r;
        mreq.a     = ext48(mp_r);
        mreq.b     = ext48(t2_r);
      end
      S_D2: begin
        mreq.start = !wait_r;
        mreq.a     = {31'd0, vmag};
        mreq.b     = {31'd0, vmag};
      end
      S_SP: begin
        mreq.start = !wait_r;
        mreq.a     = {{32{spiky_r[31]}}, spiky_r};
        mreq.b     = ext48(t2_r);
      end
      S_G: begin
        mreq.start = !wait_r;
        mreq.a     = t1_r;
        mreq.b     = ext48(s_r);
      end
      S_GG: begin
        mreq.start = !wait_r;
        mreq.a     = ext48(g_r);
        mreq.b     = ext48(g_r);
      end
      S_T: begin
        mreq.start = !wait_r;
        mreq.a     = ext48(sum_r[idx_r]);
        mreq.b     = ext48(sum_r[idx_r]);
      end
      S_RR: begin
        mreq.start = !wait_r;
        mreq.a     = {33'd0, restp};
        mreq.b     = {33'd0, restp};
      end
      default: begin
        mreq.start = 1'b0;
      end
    endcase

    dreq.start = 1'b0;
    dreq.hi    = '0;
    dreq.lo    = '0;
    dreq.d     = '0;
    unique case (state_r)
      S_UD: begin
        dreq.start = !wait_r;
        dreq.lo    = {15'd0, vmag, 16'd0};
        dreq.d     = {32'd0, dist_r};
      end
      S_GT: begin
        dreq.start = !wait_r;
        dreq.hi    = {32'd0, tot_r[63:32]};
        dreq.lo    = {tot_r[31:0], 32'd0};
        dreq.d     = rr_r;
      end
      S_Q: begin
        dreq.start = !wait_r;
        dreq.lo    = {dmag, 16'd0};
        dreq.d     = {33'd0, restp};
      end
      S_L: begin
        dreq.start = !wait_r && (cmag_r != 64'd0);
        dreq.hi    = {48'd0, cmag_r[63:48]};
        dreq.lo    = {cmag_r[47:0], 16'd0};
        dreq.d     = denom_r;
      end
      default: begin
        dreq.start = 1'b0;
      end
    endcase

    sq_start = (state_r == S_SQ) && !wait_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= pdl_pkg::RST_RADIUS;
      mass_r      <= pdl_pkg::RST_MASS;
      rest_r      <= pdl_pkg::RST_REST;
      cfm_r       <= pdl_pkg::RST_CFM;
      poly6_r     <= pdl_pkg::RST_POLY6;
      spiky_r     <= pdl_pkg::RST_SPIKY;
      state_r     <= S_IDLE;
      wait_r      <= 1'b0;
      idx_r       <= 2'd0;
      dens_r      <= '0;
      sum_r[0]    <= '0;
      sum_r[1]    <= '0;
      sum_r[2]    <= '0;
      gsq_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_paddr[4:2])
          pdl_pkg::REG_RADIUS: radius_r <= cfg_pwdata[30:0];
          pdl_pkg::REG_MASS:   mass_r   <= cfg_pwdata[30:0];
          pdl_pkg::REG_REST:   rest_r   <= cfg_pwdata[30:0];
          pdl_pkg::REG_CFM:    cfm_r    <= cfg_pwdata[30:0];
          pdl_pkg::REG_POLY6:  poly6_r  <= cfg_pwdata;
          pdl_pkg::REG_SPIKY:  spiky_r  <= cfg_pwdata;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end

      if (state_r == S_IDLE) begin
        if (in_tvalid) begin
          vec_r[0] <= {in_tdata[31], in_tdata[31:0]} - {in_tdata[127], in_tdata[127:96]};
          vec_r[1] <= {in_tdata[63], in_tdata[63:32]} - {in_tdata[159], in_tdata[159:128]};
          vec_r[2] <= {in_tdata[95], in_tdata[95:64]} - {in_tdata[191], in_tdata[191:160]};
          self_r   <= in_tuser;
          last_r   <= in_tlast;
          state_r  <= S_MP;
        end
      end else if (state_r == S_CHK) begin
        if (d2_r != 64'd0 && d2_r < hsq_r) begin
          t1_r    <= {16'd0, udiff[63:16]};
          state_r <= S_W2;
        end else begin
          state_r <= S_FIN;
        end
      end else if (state_r == S_FIN) begin
        if (last_r) begin
          tot_r   <= gsq_r;
          idx_r   <= 2'd0;
          state_r <= S_T;
        end else begin
          state_r <= S_IDLE;
        end
      end else if (state_r == S_L && !wait_r && cmag_r == 64'd0) begin
        lmag_r  <= '0;
        state_r <= S_OUT;
      end else if (state_r == S_OUT) begin
        if (out_load) begin
          od_dens_r <= pdl_pkg::sat32(dens_r);
          od_lam_r  <= lam;
          od_cnt_r  <= cnt_r;
          dens_r    <= '0;
          sum_r[0]  <= '0;
          sum_r[1]  <= '0;
          sum_r[2]  <= '0;
          gsq_r     <= '0;
          cnt_r     <= '0;
          state_r   <= S_IDLE;
        end
      end else if (!wait_r) begin
        wait_r <= 1'b1;
      end else if (unit_done) begin
        wait_r <= 1'b0;
        unique case (state_r)
          S_MP: begin
            mp_r    <= mul_res;
            idx_r   <= 2'd0;
            d2_r    <= '0;
            state_r <= self_r ? S_H2 : S_D2;
          end
          S_H2: begin
            t1_r    <= ext48(mul_res);
            state_r <= S_H4;
          end
          S_H4: begin
            t2_r    <= mul_res;
            state_r <= S_H6;
          end
          S_H6: begin
            t2_r    <= mul_res;
            state_r <= S_DS;
          end
          S_DS: begin
            dens_r  <= pdl_pkg::add48(dens_r, mul_res);
            state_r <= S_FIN;
          end
          S_D2: begin
            d2_r  <= pdl_pkg::uadd64(d2_r, mul_lo);
            idx_r <= idx_r + 2'd1;
            if (idx_r == 2'd2) state_r <= S_HS;
          end
          S_HS: begin
            hsq_r   <= mul_lo;
            state_r <= S_CHK;
          end
          S_W2: begin
            t2_r    <= mul_res;
            state_r <= S_W3;
          end
          S_W3: begin
            t2_r    <= mul_res;
            state_r <= S_WD;
          end
          S_WD: begin
            dens_r  <= pdl_pkg::add48(dens_r, mul_res);
            if (cnt_r != 16'hFFFF) cnt_r <= cnt_r + 16'd1;
            state_r <= S_SQ;
          end
          S_SQ: begin
            dist_r  <= sq_root;
            t1_r    <= $signed({33'd0, radius_r}) - $signed({32'd0, sq_root});
            state_r <= S_DD;
          end
          S_DD: begin
            t2_r    <= mul_res;
            state_r <= S_SP;
          end
          S_SP: begin
            s_r     <= mul_res;
            idx_r   <= 2'd0;
            state_r <= S_UD;
          end
          S_UD: begin
            t1_r    <= vec_r[idx_r][32] ? -$signed(div_q) : $signed(div_q);
            state_r <= S_G;
          end
          S_G: begin
            g_r          <= mul_res;
            sum_r[idx_r] <= pdl_pkg::add48(sum_r[idx_r], mul_res);
            state_r      <= S_GG;
          end
          S_GG: begin
            gsq_r   <= pdl_pkg::uadd64(gsq_r, {16'd0, mul_res});
            idx_r   <= idx_r + 2'd1;
            state_r <= (idx_r == 2'd2) ? S_FIN : S_UD;
          end
          S_T: begin
            tot_r <= pdl_pkg::uadd64(tot_r, {16'd0, mul_res});
            idx_r <= idx_r + 2'd1;
            if (idx_r == 2'd2) state_r <= S_RR;
          end
          S_RR: begin
            rr_r    <= mul_lo;
            state_r <= S_GT;
          end
          S_GT: begin
            denom_r <= pdl_pkg::uadd64(div_q, {33'd0, cfm_r});
            state_r <= S_Q;
          end
          S_Q: begin
            if (dens_r[47]) begin
              cneg_r <= 1'b1;
              cmag_r <= div_q + 64'd65536;
            end else if (div_q >= 64'd65536) begin
              cneg_r <= 1'b0;
              cmag_r <= div_q - 64'd65536;
            end else begin
              cneg_r <= 1'b1;
              cmag_r <= 64'd65536 - div_q;
            end
            state_r <= S_L;
          end
          S_L: begin
            lmag_r  <= div_q;
            state_r <= S_OUT;
          end
          default: begin
            state_r <= S_IDLE;
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (cfg_paddr[4:2])
      pdl_pkg::REG_RADIUS: cfg_prdata = {1'b0, radius_r};
      pdl_pkg::REG_MASS:   cfg_prdata = {1'b0, mass_r};
      pdl_pkg::REG_REST:   cfg_prdata = {1'b0, rest_r};
      pdl_pkg::REG_CFM:    cfg_prdata = {1'b0, cfm_r};
      pdl_pkg::REG_POLY6:  cfg_prdata = poly6_r;
      pdl_pkg::REG_SPIKY:  cfg_prdata = spiky_r;
      default:             cfg_prdata = 32'd0;
    endcase
  end

  assign cfg_pready = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {od_cnt_r, od_lam_r, od_dens_r};

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("accepted item did not start work");

  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (dens_r == 48'sd0 && cnt_r == 16'd0 && gsq_r == 64'd0 && out_tvalid))
    else $error("accumulators not cleared after a result");

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != $past(cnt_r)) |-> (cnt_r == $past(cnt_r) + 16'd1 || cnt_r == 16'd0))
    else $error("neighbour count moved by more than one");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam longint Q47 = 64'sh7FFF_FFFF_FFFF;
  localparam int LIMIT = 20000;
  localparam int SETTLE = 800;
  localparam int HOLD_LEN = 3000;

  typedef struct {
    logic signed [31:0] cx, cy, cz, nx, ny, nz;
    logic self_f, last_f;
  } record_t;

  typedef struct {
    logic signed [31:0] density;
    logic signed [31:0] lambda;
    logic [15:0] count;
  } particle_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [191:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [79:0] out_tdata;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  pbf_density_lambda DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow of the block's registers and accumulators.
  logic [30:0] radius_r = pdl_pkg::RST_RADIUS;
  logic [30:0] mass_r = pdl_pkg::RST_MASS;
  logic [30:0] rest_r = pdl_pkg::RST_REST;
  logic [30:0] cfm_r = pdl_pkg::RST_CFM;
  logic signed [31:0] poly6_r = pdl_pkg::RST_POLY6;
  logic signed [31:0] spiky_r = pdl_pkg::RST_SPIKY;
  longint dens_acc, gx_acc, gy_acc, gz_acc;
  logic [63:0] gsq_acc;
  logic [15:0] nbr_acc;

  particle_t expected_q[$];
  int errors = 0;
  int sent = 0;
  bit no_idle = 0;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int stall_left = 0;
  int quiet_cycles = 0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [63:0] mag(longint a);
    logic [63:0] m;
    m = a;
    return a < 0 ? -m : m;
  endfunction

  function automatic longint mul_q16(longint a, longint b);
    logic [127:0] p;
    logic [63:0] m;
    logic neg;
    neg = (a < 0) != (b < 0);
    p = {64'd0, mag(a)} * {64'd0, mag(b)};
    if (p[127:64] >= 64'h10000) m = Q47;
    else m = p[79:16];
    if (m > Q47) m = Q47;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint acc_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > Q47) return Q47;
    if (s < -Q47) return -Q47;
    return s;
  endfunction

  function automatic logic [63:0] sum_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [63:0] quot_sat(logic [63:0] hi, logic [63:0] lo, logic [63:0] d);
    logic [127:0] q;
    if (d == 0 || hi >= d) return '1;
    q = {hi, lo} / {64'd0, d};
    return q[63:0];
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic clear_particle();
    dens_acc = 0;
    gx_acc = 0;
    gy_acc = 0;
    gz_acc = 0;
    gsq_acc = 0;
    nbr_acc = 0;
  endtask

  task automatic predict_record(record_t rec);
    longint h, mp, h2, h6, w, w3, root_d, delta, s, us, lam;
    longint v[3], g[3];
    logic [63:0] hsq, d2, u, rest, tot, gterm, denom, q, cmag, lmag;
    logic cneg;
    particle_t p;
    h = radius_r;
    hsq = {33'd0, radius_r} * {33'd0, radius_r};
    mp = mul_q16(mass_r, poly6_r);
    v[0] = longint'(rec.cx) - longint'(rec.nx);
    v[1] = longint'(rec.cy) - longint'(rec.ny);
    v[2] = longint'(rec.cz) - longint'(rec.nz);
    if (rec.self_f) begin
      h2 = mul_q16(h, h);
      h6 = mul_q16(mul_q16(h2, h2), h2);
      dens_acc = acc_add(dens_acc, mul_q16(mp, h6));
    end else begin
      d2 = 0;
      for (int i = 0; i < 3; i++) d2 = sum_sat(d2, mag(v[i]) * mag(v[i]));
      if (d2 != 0 && d2 < hsq) begin
        w = (hsq - d2) >> 16;
        w3 = mul_q16(mul_q16(w, w), w);
        root_d = root_floor(d2);
        delta = h - root_d;
        s = mul_q16(spiky_r, mul_q16(delta, delta));
        dens_acc = acc_add(dens_acc, mul_q16(mp, w3));
        if (nbr_acc != 16'hFFFF) nbr_acc++;
        for (int i = 0; i < 3; i++) begin
          u = (mag(v[i]) << 16) / root_d;
          us = v[i] < 0 ? -longint'(u) : longint'(u);
          g[i] = mul_q16(us, s);
          gsq_acc = sum_sat(gsq_acc, mul_q16(g[i], g[i]));
        end
        gx_acc = acc_add(gx_acc, g[0]);
        gy_acc = acc_add(gy_acc, g[1]);
        gz_acc = acc_add(gz_acc, g[2]);
      end
    end
    if (!rec.last_f) return;
    rest = rest_r != 0 ? {33'd0, rest_r} : 64'd1;
    tot = sum_sat(gsq_acc, mul_q16(gx_acc, gx_acc));
    tot = sum_sat(tot, mul_q16(gy_acc, gy_acc));
    tot = sum_sat(tot, mul_q16(gz_acc, gz_acc));
    gterm = quot_sat(tot >> 32, tot << 32, rest * rest);
    denom = sum_sat(gterm, {33'd0, cfm_r});
    q = (mag(dens_acc) << 16) / rest;
    if (dens_acc < 0) begin
      cneg = 1;
      cmag = q + 65536;
    end else if (q >= 65536) begin
      cneg = 0;
      cmag = q - 65536;
    end else begin
      cneg = 1;
      cmag = 65536 - q;
    end
    lmag = cmag == 0 ? 64'd0 : quot_sat(cmag >> 48, cmag << 16, denom);
    if (!cneg) lam = lmag >= 64'h8000_0000 ? -64'sd2147483648 : -longint'(lmag);
    else lam = lmag >= 64'h7FFF_FFFF ? 64'sd2147483647 : longint'(lmag);
    if (dens_acc > 64'sd2147483647) p.density = 32'sh7FFF_FFFF;
    else if (dens_acc < -64'sd2147483648) p.density = 32'sh8000_0000;
    else p.density = dens_acc[31:0];
    p.lambda = lam[31:0];
    p.count = nbr_acc;
    expected_q = {expected_q, p};
    clear_particle();
  endtask

  task automatic send_record(record_t rec);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {rec.nz, rec.ny, rec.nx, rec.cz, rec.cy, rec.cx};
    in_tuser <= rec.self_f;
    in_tlast <= rec.last_f;
    do @(posedge clk); while (!in_tready);
    predict_record(rec);
    sent++;
  endtask

  task automatic stop_sending();
    in_tvalid <= 1'b0;
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      pdl_pkg::REG_RADIUS: radius_r = value[30:0];
      pdl_pkg::REG_MASS:   mass_r = value[30:0];
      pdl_pkg::REG_REST:   rest_r = value[30:0];
      pdl_pkg::REG_CFM:    cfm_r = value[30:0];
      pdl_pkg::REG_POLY6:  poly6_r = value;
      pdl_pkg::REG_SPIKY:  spiky_r = value;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    stop_sending();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_coefs(logic [31:0] h, logic [31:0] m, logic [31:0] r, logic [31:0] c,
                           logic [31:0] p6, logic [31:0] sp);
    wait_idle();
    cfg_write(pdl_pkg::REG_RADIUS, h);
    cfg_write(pdl_pkg::REG_MASS, m);
    cfg_write(pdl_pkg::REG_REST, r);
    cfg_write(pdl_pkg::REG_CFM, c);
    cfg_write(pdl_pkg::REG_POLY6, p6);
    cfg_write(pdl_pkg::REG_SPIKY, sp);
  endtask

  function automatic record_t make_record(logic signed [31:0] cx, cy, cz, nx, ny, nz,
                                          logic self_f, logic last_f);
    record_t rec;
    rec.cx = cx; rec.cy = cy; rec.cz = cz;
    rec.nx = nx; rec.ny = ny; rec.nz = nz;
    rec.self_f = self_f;
    rec.last_f = last_f;
    return rec;
  endfunction

  function automatic record_t random_record(logic self_f, logic last_f);
    record_t rec;
    longint span;
    int kind;
    rec.cx = $urandom; rec.cy = $urandom; rec.cz = $urandom;
    rec.self_f = self_f;
    rec.last_f = last_f;
    kind = $urandom_range(0, 99);
    span = radius_r != 0 ? longint'(radius_r) : 64'd1;
    if (kind < 75) begin
      rec.nx = 32'(rec.cx + ($urandom_range(0, span[31:0]) - span / 2));
      rec.ny = 32'(rec.cy + ($urandom_range(0, span[31:0]) - span / 2));
      rec.nz = 32'(rec.cz + ($urandom_range(0, span[31:0]) - span / 2));
    end else if (kind < 85) begin
      rec.nx = rec.cx; rec.ny = rec.cy; rec.nz = rec.cz;
    end else begin
      rec.nx = $urandom; rec.ny = $urandom; rec.nz = $urandom;
    end
    return rec;
  endfunction

  task automatic send_particles(int n_items);
    int len, stop_at;
    stop_at = sent + n_items;
    while (sent < stop_at) begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        send_record(random_record(i == 0 && $urandom_range(0, 9) < 7, i == len - 1));
    end
  endtask

  task automatic test_directed();
    send_record(make_record(0, 0, 0, 0, 0, 0, 1, 1));
    send_record(make_record(5, 6, 7, 1000000, 0, 0, 0, 1));
    send_record(make_record(0, 0, 0, 0, 0, 0, 0, 1));
    send_record(make_record(100, 200, 300, 100, 200, 300, 1, 0));
    send_record(make_record(0, 0, 0, 32768, 0, 0, 0, 0));
    send_record(make_record(0, 0, 0, 0, -20000, 10000, 0, 0));
    send_record(make_record(0, 0, 0, 0, 0, 0, 0, 0));
    send_record(make_record(0, 0, 0, 65536, 0, 0, 0, 0));
    send_record(make_record(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 0, 1));
    send_record(make_record(32'sh7FFF_FFFF, 32'sh8000_0000, -1,
                            32'sh7FFF_F000, 32'sh8000_1000, 100, 1, 0));
    send_record(make_record(-1, -1, -1, -1, -30000, -1, 0, 1));
    // Zero relaxation gives a zero denominator for an empty run.
    set_coefs(65536, 65536, 65536000, 0, 102681, -938731);
    send_record(make_record(0, 0, 0, 1000000, 0, 0, 0, 1));
    send_record(make_record(0, 0, 0, 0, 0, 0, 1, 1));
    // Zero radius skips every neighbour; zero rest density counts as a raw value of one.
    set_coefs(0, 65536, 0, 6553600, 102681, -938731);
    send_record(make_record(0, 0, 0, 1, 0, 0, 0, 0));
    send_record(make_record(0, 0, 0, 0, 0, 0, 1, 1));
    // Register maxima and minima.
    set_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000);
    send_record(make_record(0, 0, 0, 0, 0, 0, 1, 0));
    send_record(make_record(0, 0, 0, 32'sh4000_0000, 32'sh2000_0000, -5, 0, 1));
    set_coefs(1, 1, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_record(make_record(0, 0, 0, 0, 0, 0, 1, 0));
    send_record(make_record(0, 0, 0, 0, 0, 1, 0, 1));
  endtask

  task automatic test_random_phases();
    set_coefs(65536, 65536, 65536000, 6553600, 102681, -938731);
    send_particles(150);
    no_idle = 1;
    send_particles(60);
    no_idle = 0;
    for (int k = 0; k < 6; k++) begin
      set_coefs($urandom_range(1 << 10, 1 << 22), $urandom_range(1, 32'h7FFF_FFFF),
                $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 30),
                $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 30),
                $urandom, $urandom);
      send_particles(70);
    end
    set_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_particles(40);
    set_coefs(1 << 16, 1, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000);
    send_particles(30);
  endtask

  task automatic test_backpressure();
    set_coefs(65536, 65536, 65536000, 6553600, 102681, -938731);
    hold_req++;
    no_idle = 1;
    for (int i = 0; i < 12; i++) send_record(random_record(i % 2 == 0, i % 2 == 1));
    no_idle = 0;
    send_particles(20);
  endtask

  always @(posedge clk) begin
    particle_t want;
    particle_t got;
    int gap;
    if (rst_n && out_tvalid && out_tready) begin
      got.density = out_tdata[31:0];
      got.lambda = out_tdata[63:32];
      got.count = out_tdata[79:64];
      if (expected_q.size() == 0) begin
        $error("unexpected result: density %0d lambda %0d count %0d",
               got.density, got.lambda, got.count);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.density !== want.density) begin
          $error("density_out: expected %0d, got %0d", want.density, got.density);
          errors++;
        end
        if (got.lambda !== want.lambda) begin
          $error("lambda_out: expected %0d, got %0d", want.lambda, got.lambda);
          errors++;
        end
        if (got.count !== want.count) begin
          $error("neighbor_count: expected %0d, got %0d", want.count, got.count);
          errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done++;
      hold_left = HOLD_LEN;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      gap = pick_gap();
      stall_left = gap > 0 ? gap - 1 : 0;
      out_tready <= gap == 0;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clear_particle();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    wait_idle();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/pdl_pkg.sv
sv/pdl_mul.sv
sv/pdl_div.sv
sv/pdl_sqrt.sv
sv/pbf_density_lambda.sv
tb/sv/tb.sv
